[rtl/ncas_pkg.sv]
// Shared types and constants for the NAND command/address cycle sequencer.
// No dependencies; imported by the decoder, the emitter, the top level and the testbench.
package ncas_pkg;

    localparam int unsigned SLOTS     = 7;
    localparam int unsigned SLOT_W    = $clog2(SLOTS);
    localparam int unsigned IN_DATA_W = 40;

    localparam logic [7:0] CMD_SEQ_INPUT  = 8'h80;
    localparam logic [7:0] CMD_RESET      = 8'hFF;
    localparam logic [7:0] CMD_READ_SPARE = 8'h50;
    localparam logic [7:0] CMD_READ_HALF2 = 8'h01;
    localparam logic [7:0] CMD_READ_HALF1 = 8'h00;

    localparam logic CFG_PAGE_IS_512   = 1'b0;
    localparam logic CFG_FOURTH_ADDR   = 1'b1;

    typedef struct packed {
        logic [19:0] page_num;
        logic        has_page;
        logic [9:0]  column;
        logic        has_column;
        logic [7:0]  command;
    } request_t;

    typedef struct packed {
        logic page_is_512;
        logic fourth_address_cycle;
    } cfg_t;

    // Bus cycles of one request, in order, with the index of the final one.
    typedef struct packed {
        logic [SLOTS-1:0][7:0] bytes;
        logic [SLOTS-1:0]      is_addr;
        logic [SLOT_W-1:0]     last_idx;
    } plan_t;

endpackage

[rtl/ncas_decode.sv]
// Request decoder: turns one request into the ordered list of bus cycles.
// Depends on ncas_pkg.
module ncas_decode
    import ncas_pkg::*;
(
    input  request_t req,
    input  cfg_t     cfg,
    output plan_t    plan
);

    logic [7:0]        cand [SLOTS];
    logic [SLOTS-1:0]  cand_en;
    logic [SLOTS-1:0]  cand_addr;
    logic [SLOT_W-1:0] fill;
    logic [9:0]        col_eff;

    // Rebasing the column by 256 or 512 never touches its low byte, so the
    // column cycle always carries column[7:0].
    always_comb begin
        col_eff   = req.has_column ? req.column : 10'd0;
        cand[0]   = CMD_READ_HALF1;
        cand[1]   = CMD_SEQ_INPUT;
        cand[2]   = CMD_SEQ_INPUT;
        cand_en   = '0;
        cand_addr = 7'b1111000;
        if (req.command != CMD_SEQ_INPUT) begin
            cand[0]    = req.command;
            cand_en[0] = 1'b1;
        end else if (!cfg.page_is_512 && col_eff[9:8] != 2'b00) begin
            cand[0]      = CMD_RESET;
            cand[1]      = CMD_READ_SPARE;
            cand_en[2:0] = 3'b111;
        end else if (cfg.page_is_512 && col_eff[9]) begin
            cand[0]      = CMD_READ_SPARE;
            cand_en[1:0] = 2'b11;
        end else if (cfg.page_is_512 && col_eff[8]) begin
            cand[0]      = CMD_READ_HALF2;
            cand_en[1:0] = 2'b11;
        end else begin
            cand_en[1:0] = 2'b11;
        end
        cand[3]    = req.column[7:0];
        cand[4]    = req.page_num[7:0];
        cand[5]    = req.page_num[15:8];
        cand[6]    = {4'd0, req.page_num[19:16]};
        cand_en[3] = req.has_column;
        cand_en[4] = req.has_page;
        cand_en[5] = req.has_page;
        cand_en[6] = req.has_page && cfg.fourth_address_cycle;
    end

    // Pack the enabled cycles into consecutive slots.
    always_comb begin
        plan = '0;
        fill = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (cand_en[i]) begin
                plan.bytes[fill]   = cand[i];
                plan.is_addr[fill] = cand_addr[i];
                fill               = fill + SLOT_W'(1);
            end
        end
        plan.last_idx = fill - SLOT_W'(1);
    end

endmodule

[rtl/ncas_emit.sv]
// Cycle emitter: holds one decoded request and walks its bus cycles into the
// output register, one per transfer. Depends on ncas_pkg.
module ncas_emit
    import ncas_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  plan_t      plan_in,
    output logic       free,
    output logic [7:0] out_byte,
    output logic       out_addr,
    output logic       out_last,
    output logic       out_valid,
    input  logic       out_ready
);

    plan_t             plan_reg;
    logic              plan_valid_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_addr_reg;
    logic              out_last_reg;
    logic              move;
    logic              at_last;

    assign move     = plan_valid_reg && (!out_valid_reg || out_ready);
    assign at_last  = (idx_reg == plan_reg.last_idx);
    assign free     = !plan_valid_reg || (move && at_last);
    assign idx_next = at_last ? '0 : idx_reg + SLOT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (move) begin
                idx_reg <= idx_next;
            end
            if (load) begin
                plan_valid_reg <= 1'b1;
            end else if (move && at_last) begin
                plan_valid_reg <= 1'b0;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            plan_reg <= plan_in;
        end
        if (move) begin
            out_byte_reg <= plan_reg.bytes[idx_reg];
            out_addr_reg <= plan_reg.is_addr[idx_reg];
            out_last_reg <= at_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_addr  = out_addr_reg;
    assign out_last  = out_last_reg;

endmodule

[rtl/nand_command_address_sequencer.sv]
// Top level of the NAND command/address cycle sequencer.
// Depends on ncas_pkg, ncas_decode and ncas_emit.
//
//   Channel | Direction | Ports                          | Carries
//   --------+-----------+--------------------------------+------------------------------
//   s_      | in        | s_tvalid s_tready s_tdata      | one request per transfer
//   m_      | out       | m_tvalid m_tready m_tdata/user | one bus cycle per transfer
//   cfg_    | in        | cfg_wr_en cfg_index cfg_wdata  | register writes, no read-back
//
// A request is decoded as it is accepted into a plan register, and the emitter
// then moves one bus cycle per clock, unless stalled, from that plan into the
// output register; a request makes 1 to 7 bus cycles (one command cycle, or
// two prefix or three reset-prefix ones, then an optional column cycle and two
// or three page cycles). The plan register frees in the same cycle its final
// bus cycle moves out, so the next request is accepted then and there is no
// gap between requests while m_tready stays high. When m_tready is low the
// output register holds its transfer, the plan holds, and s_tready drops once
// a plan is waiting. Reset (aresetn low, sampled on aclk) empties both
// registers and restores 512-byte pages with two page-address cycles.
module nand_command_address_sequencer
    import ncas_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Fields from bit 0 up: command[7:0], has_column[8], column[18:9],
    // has_page[19], page_num[39:20].
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // bus_byte[7:0].
    output logic [7:0]           m_tdata,
    // is_address[0]: 1 for an address latch cycle, 0 for a command latch cycle.
    output logic                 m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic                 cfg_wdata
);

    cfg_t     cfg_reg;
    request_t req;
    plan_t    plan;
    logic     load;

    // Configuration registers; both indexes of the one-bit index are defined.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.page_is_512          <= 1'b1;
            cfg_reg.fourth_address_cycle <= 1'b0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_PAGE_IS_512) begin
                cfg_reg.page_is_512 <= cfg_wdata;
            end else begin
                cfg_reg.fourth_address_cycle <= cfg_wdata;
            end
        end
    end

    assign req  = request_t'(s_tdata);
    assign load = s_tvalid && s_tready;

    ncas_decode u_decode (
        .req  (req),
        .cfg  (cfg_reg),
        .plan (plan)
    );

    ncas_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .plan_in   (plan),
        .free      (s_tready),
        .out_byte  (m_tdata),
        .out_addr  (m_tuser),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule

[rtl/ncas_checker.sv]
// Port-level checks for the NAND command/address cycle sequencer, bound to
// the top level. Depends on nand_command_address_sequencer.
module ncas_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled transfer keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    // The output is empty right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Within one request the bus cycles follow each other without a bubble.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a request");

    // Once address cycles begin, no command cycle follows in the same request.
    a_addr_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && m_tuser |=> m_tuser)
        else $error("command cycle after an address cycle");

endmodule

bind nand_command_address_sequencer ncas_checker u_ncas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[sim/nand_command_address_sequencer_tb.sv]
// Self-checking testbench for the NAND command/address cycle sequencer.
// Depends on ncas_pkg and nand_command_address_sequencer; a built-in predictor
// derives every bus cycle from each accepted request and checks the output stream.
`timescale 1ns / 1ps

module nand_command_address_sequencer_tb;
    import ncas_pkg::*;

    // Commands other than the pointer-setting ones, used to exercise the
    // single-cycle path with opcodes a real controller would issue.
    localparam logic [7:0] CMD_READ_STATUS  = 8'h70;
    localparam logic [7:0] CMD_READ_ID      = 8'h90;
    localparam logic [7:0] CMD_ERASE_SETUP  = 8'h60;
    localparam logic [7:0] CMD_ERASE_GO     = 8'hD0;
    localparam logic [7:0] CMD_PROGRAM_GO   = 8'h10;

    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned ITEMS_PER_PHASE = 51;

    // One bus cycle as seen on the result channel.
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_address;
        logic       last;
    } bus_cycle_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [IN_DATA_W-1:0] s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = 1'b0;
    logic                 cfg_wdata = 1'b0;

    // Our own copy of the two registers, updated at the edge a write lands.
    cfg_t                 cfg_shadow;

    // Bus cycles still owed by the block, oldest first.
    bus_cycle_t           owed_cycles[$];
    int unsigned          mismatch_count = 0;

    // Sender pacing: transfers left in the current burst.
    int unsigned          burst_left = 0;

    int unsigned          column_edges[8] = '{0, 255, 256, 511, 512, 527, 528, 1023};

    always #1 aclk = ~aclk;

    nand_command_address_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    function automatic bus_cycle_t bus_cycle(input logic [7:0] b, input logic addr);
        bus_cycle_t c;
        c.bus_byte   = b;
        c.is_address = addr;
        c.last       = 1'b0;
        return c;
    endfunction

    // Expands one request into the bus cycles it must produce under the
    // current register settings and appends them to the owed list.
    function automatic void expand_request(input request_t req);
        bus_cycle_t  seq[$];
        logic [9:0]  col;
        bus_cycle_t  c;

        // A request without a column is treated as if it addressed the
        // first half, so a sequential input then gets the plain prefix.
        col = req.has_column ? req.column : 10'd0;

        if (req.command != CMD_SEQ_INPUT) begin
            seq.push_back(bus_cycle(req.command, 1'b0));
        end else if (!cfg_shadow.page_is_512 && col >= 10'd256) begin
            // 256-byte pages: the spare area needs a reset before the
            // spare pointer can be set.
            col = col - 10'd256;
            seq.push_back(bus_cycle(CMD_RESET, 1'b0));
            seq.push_back(bus_cycle(CMD_READ_SPARE, 1'b0));
            seq.push_back(bus_cycle(CMD_SEQ_INPUT, 1'b0));
        end else if (cfg_shadow.page_is_512 && col >= 10'd256) begin
            if (col < 10'd512) begin
                col = col - 10'd256;
                seq.push_back(bus_cycle(CMD_READ_HALF2, 1'b0));
            end else begin
                col = col - 10'd512;
                seq.push_back(bus_cycle(CMD_READ_SPARE, 1'b0));
            end
            seq.push_back(bus_cycle(CMD_SEQ_INPUT, 1'b0));
        end else begin
            seq.push_back(bus_cycle(CMD_READ_HALF1, 1'b0));
            seq.push_back(bus_cycle(CMD_SEQ_INPUT, 1'b0));
        end

        // Only the low byte of the rebased column goes out, so columns past
        // the spare area wrap.
        if (req.has_column)
            seq.push_back(bus_cycle(col[7:0], 1'b1));
        if (req.has_page) begin
            seq.push_back(bus_cycle(req.page_num[7:0], 1'b1));
            seq.push_back(bus_cycle(req.page_num[15:8], 1'b1));
            if (cfg_shadow.fourth_address_cycle)
                seq.push_back(bus_cycle({4'h0, req.page_num[19:16]}, 1'b1));
        end

        foreach (seq[i]) begin
            c      = seq[i];
            c.last = (i == seq.size() - 1);
            owed_cycles.push_back(c);
        end
    endfunction

    // Presents one request and holds it until the block takes it. The valid
    // stays high across a burst; at the end of a burst it drops for a random
    // gap, during which the data lines carry junk.
    task automatic send_request(input request_t req);
        s_tdata  <= req;
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        expand_request(req);

        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_DATA_W'({$urandom, $urandom});
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic send_fields(input logic [7:0] cmd, input logic has_col,
                               input logic [9:0] col, input logic has_pg,
                               input logic [19:0] pg);
        request_t req;
        req.command    = cmd;
        req.has_column = has_col;
        req.column     = col;
        req.has_page   = has_pg;
        req.page_num   = pg;
        send_request(req);
    endtask

    // Stops sending and waits until every owed bus cycle has come out, then
    // idles on to let anything still in flight inside the block settle.
    task automatic wait_for_drain();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        burst_left = 0;
        while (owed_cycles.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Register writes only happen with the block idle, so the shadow copy
    // can change at the same edge as the hardware.
    task automatic write_register(input logic index, input logic value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        if (index == CFG_PAGE_IS_512)
            cfg_shadow.page_is_512 = value;
        else if (index == CFG_FOURTH_ADDR)
            cfg_shadow.fourth_address_cycle = value;
        cfg_wr_en <= 1'b0;
        cfg_wdata <= 1'($urandom_range(0, 1));
        @(posedge aclk);
    endtask

    // Settings after reset: 512-byte pages, two page-address cycles.
    task automatic test_reset_defaults();
        // Plain commands with nothing after them, and one with fields.
        send_fields(CMD_READ_STATUS, 1'b0, 10'd0, 1'b0, 20'h00000);
        send_fields(CMD_RESET, 1'b0, 10'd1023, 1'b0, 20'hFFFFF);
        send_fields(CMD_READ_HALF1, 1'b1, 10'd0, 1'b1, 20'h00000);
        // Sequential input with neither column nor page: prefix only, the
        // final command cycle carries the last flag.
        send_fields(CMD_SEQ_INPUT, 1'b0, 10'd0, 1'b0, 20'h00000);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd0, 1'b1, 20'h00000);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd255, 1'b1, 20'hFFFFF);
        // Second half and spare area boundaries.
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd256, 1'b1, 20'h12345);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd511, 1'b0, 20'h00000);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd512, 1'b1, 20'hA5A5A);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd527, 1'b1, 20'h5A5A5);
        // Column past the spare area wraps after rebasing.
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd1023, 1'b1, 20'h0F0F0);
        // A column value that is flagged absent must not move the pointer.
        send_fields(CMD_SEQ_INPUT, 1'b0, 10'd1023, 1'b1, 20'hF0F0F);
        wait_for_drain();
    endtask

    // 256-byte pages: the spare area takes the reset-prefixed sequence.
    task automatic test_small_pages();
        write_register(CFG_PAGE_IS_512, 1'b0);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd255, 1'b1, 20'h00001);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd256, 1'b1, 20'h80000);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd527, 1'b0, 20'h00000);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd1023, 1'b1, 20'hFFFFF);
        send_fields(CMD_SEQ_INPUT, 1'b0, 10'd0, 1'b0, 20'h00000);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd300, 1'b0, 20'h00000);
        wait_for_drain();
    endtask

    // Third page-address byte, under both page sizes; the reset-prefixed
    // case with all fields gives the longest request.
    task automatic test_fourth_cycle();
        write_register(CFG_FOURTH_ADDR, 1'b1);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd600, 1'b1, 20'hFFFFF);
        send_fields(CMD_READ_ID, 1'b0, 10'd0, 1'b1, 20'h5A5A5);
        wait_for_drain();
        write_register(CFG_PAGE_IS_512, 1'b1);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd520, 1'b1, 20'hFFFFF);
        send_fields(CMD_SEQ_INPUT, 1'b1, 10'd100, 1'b1, 20'h00000);
        wait_for_drain();
    endtask

    function automatic request_t random_request();
        request_t req;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: req.command = CMD_SEQ_INPUT;
            5: req.command = CMD_READ_STATUS;
            6: begin
                case ($urandom_range(0, 3))
                    0: req.command = CMD_ERASE_SETUP;
                    1: req.command = CMD_ERASE_GO;
                    2: req.command = CMD_PROGRAM_GO;
                    default: req.command = CMD_READ_ID;
                endcase
            end
            default: req.command = 8'($urandom_range(0, 255));
        endcase
        req.has_column = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 5))
            0: req.column = 10'($urandom_range(0, 255));
            1: req.column = 10'($urandom_range(256, 511));
            2: req.column = 10'($urandom_range(512, 527));
            3: req.column = 10'(column_edges[$urandom_range(0, 7)]);
            default: req.column = 10'($urandom_range(0, 1023));
        endcase
        req.has_page = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0: req.page_num = 20'h00000;
            1: req.page_num = 20'hFFFFF;
            default: req.page_num = 20'($urandom_range(0, 20'hFFFFF));
        endcase
        return req;
    endfunction

    // Random requests under every register combination, then under random
    // settings, with a drain before each change.
    task automatic test_random_requests();
        logic [1:0] setting;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            setting = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
            write_register(CFG_PAGE_IS_512, setting[0]);
            write_register(CFG_FOURTH_ADDR, setting[1]);
            repeat (ITEMS_PER_PHASE) send_request(random_request());
            wait_for_drain();
        end
    endtask

    // The receiver switches between stretches of steady readiness, random
    // stalls and mostly-stalled operation, so backpressure lands on every
    // cycle of a request.
    int unsigned ready_mode      = 0;
    int unsigned ready_mode_left = 0;

    always @(posedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode      = $urandom_range(0, 2);
            ready_mode_left = $urandom_range(8, 64);
        end else begin
            ready_mode_left--;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compares every output transfer with the oldest owed bus cycle.
    always @(posedge aclk) begin
        bus_cycle_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_cycles.size() == 0) begin
                $error("unexpected bus cycle: bus_byte=%02h is_address=%0b last=%0b",
                       m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                want = owed_cycles.pop_front();
                if (m_tdata !== want.bus_byte) begin
                    $error("bus_byte: expected %02h, got %02h", want.bus_byte, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.is_address) begin
                    $error("is_address: expected %0b, got %0b", want.is_address, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        cfg_shadow.page_is_512          = 1'b1;
        cfg_shadow.fourth_address_cycle = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_small_pages();
        test_fourth_cycle();
        test_random_requests();
        wait_for_drain();

        if (mismatch_count == 0 && owed_cycles.size() == 0)
            $display("nand_command_address_sequencer regression: pass");
        else
            $display("nand_command_address_sequencer regression: fail");
        $finish;
    end

    // Well beyond the slowest correct run: up to seven bus cycles per request,
    // each held off by the receiver, plus the sender's gaps.
    initial begin
        #1000000;
        $display("nand_command_address_sequencer regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/ncas_pkg.sv
rtl/ncas_decode.sv
rtl/ncas_emit.sv
rtl/nand_command_address_sequencer.sv
rtl/ncas_checker.sv
sim/nand_command_address_sequencer_tb.sv
